>>> hdl/keyed_min_table_topn_macros.svh
// Assertion macros used by the top level of the keyed minimum table.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef KEYED_MIN_TABLE_TOPN_MACROS_SVH
`define KEYED_MIN_TABLE_TOPN_MACROS_SVH

`define KMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define KMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/kmt_pkg.sv
// Package of the keyed minimum table: word types, sizes and codes.
// Depends on nothing.
package kmt_pkg;

  localparam int KMT_CAPACITY   = 16;
  localparam int KMT_DATA_WIDTH = 64;
  localparam int FIELD_W        = 64;
  localparam int LIMIT_W        = 6;

  localparam logic CFG_KEY_LIMIT  = 1'b0;
  localparam logic CFG_DESCENDING = 1'b1;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] value;
    logic               value_null;
    logic               condition;
    logic               condition_null;
    logic [FIELD_W-1:0] category;
    logic               category_null;
  } in_word_t;

  typedef struct packed {
    logic               entry_valid;
    logic [FIELD_W-1:0] entry_key;
    logic [FIELD_W-1:0] min_value;
    logic               overflowed;
    logic               last;
  } out_word_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_INS   = 7'b0001000,
    S_EVCHK = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

endpackage

>>> hdl/kmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/keyed_min_table_topn.sv
// Top level of the keyed minimum table: sorted key table with minimum per key.
// Depends on kmt_pkg, kmt_ram and keyed_min_table_topn_macros.svh.
//
//   channel | direction | handshake        | word
//   in      | input     | in_valid/ready   | in_data (in_word_t)
//   out     | output    | out_valid/ready  | out_data (out_word_t)
//   cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// An update runs in steps from acceptance: the search reads one entry a cycle, the
// shift moves one entry a cycle, and then the insert and the limit check follow.
// An eviction adds a shift that drops the smallest entry. An emit reads the entries
// in turn and waits on any output stall; the output register holds each word.
// Reset is synchronous and empties the table at once through the entry count.
module keyed_min_table_topn
  import kmt_pkg::*;
#(
  parameter int CAPACITY   = KMT_CAPACITY,
  parameter int DATA_WIDTH = KMT_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

`include "keyed_min_table_topn_macros.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 2 * DATA_WIDTH;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           p_r, p_nxt;
  logic [CW-1:0]           src_r, src_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           orem_r, orem_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  logic [AW-1:0]           ins_r, ins_nxt;
  logic                    rdv_r, rdv_nxt;
  logic                    up_r, up_nxt;
  logic                    insf_r, insf_nxt;
  logic                    evc_r, evc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DATA_WIDTH-1:0]   key_r, key_nxt;
  logic [DATA_WIDTH-1:0]   val_r, val_nxt;
  logic [LIMIT_W-1:0]      lim_r;
  logic                    desc_r;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [RW-1:0]           ram_wdata, ram_rdata;
  logic [DATA_WIDTH-1:0]   q_key, q_min;
  logic                    lim_act, lim_fits, over_lim, nf, free, loadnow;

  kmt_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_key    = ram_rdata[RW-1:DATA_WIDTH];
  assign q_min    = ram_rdata[DATA_WIDTH-1:0];
  assign lim_act  = !lim_r[LIMIT_W-1];
  assign lim_fits = 32'(lim_r[LIMIT_W-2:0]) <= 32'(CAPACITY);
  assign over_lim = lim_act && (32'(cnt_r) > 32'(lim_r[LIMIT_W-2:0]));
  assign free     = !out_valid_r || out_ready;
  assign loadnow  = rdv_r && free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    orem_nxt      = orem_r;
    last_nxt      = last_r;
    ins_nxt       = ins_r;
    rdv_nxt       = rdv_r;
    up_nxt        = up_r;
    insf_nxt      = insf_r;
    evc_nxt       = evc_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    nf            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.category[DATA_WIDTH-1:0];
          val_nxt = in_data.value[DATA_WIDTH-1:0];
          rdv_nxt = 1'b0;
          if (in_data.op) begin
            rem_nxt   = cnt_r;
            orem_nxt  = cnt_r;
            up_nxt    = !desc_r;
            src_nxt   = desc_r ? cnt_r - CW'(1) : '0;
            state_nxt = S_EMIT;
          end else if (in_data.condition && !in_data.condition_null) begin
            p_nxt = '0;
            if (in_data.value_null || in_data.category_null) begin
              state_nxt = S_EVCHK;
            end else begin
              state_nxt = S_SRCH;
            end
          end
        end
      end
      S_SRCH: begin
        if (p_r == cnt_r) begin
          nf = 1'b1;
        end else if (!rdv_r) begin
          ram_re    = 1'b1;
          ram_raddr = p_r[AW-1:0];
          rdv_nxt   = 1'b1;
        end else if ($signed(q_key) < $signed(key_r)) begin
          p_nxt = p_r + CW'(1);
          if (p_r + CW'(1) < cnt_r) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(p_r + CW'(1));
          end else begin
            rdv_nxt = 1'b0;
          end
        end else if (q_key == key_r) begin
          rdv_nxt = 1'b0;
          if ($signed(val_r) < $signed(q_min)) begin
            ram_we    = 1'b1;
            ram_waddr = p_r[AW-1:0];
            ram_wdata = {key_r, val_r};
          end
          state_nxt = S_EVCHK;
        end else begin
          nf = 1'b1;
        end
      end
      S_SHIFT: begin
        if (rdv_r) begin
          ram_we    = 1'b1;
          ram_waddr = up_r ? last_r + AW'(1) : last_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (rem_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_r[AW-1:0];
          last_nxt  = src_r[AW-1:0];
          src_nxt   = up_r ? src_r - CW'(1) : src_r + CW'(1);
          rem_nxt   = rem_r - CW'(1);
          rdv_nxt   = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            state_nxt = insf_r ? S_INS : S_IDLE;
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ins_r;
        ram_wdata = {key_r, val_r};
        state_nxt = evc_r ? S_EVCHK : S_IDLE;
      end
      S_EVCHK: begin
        if (over_lim && cnt_r != '0) begin
          cnt_nxt   = cnt_r - CW'(1);
          up_nxt    = 1'b0;
          src_nxt   = CW'(1);
          rem_nxt   = cnt_r - CW'(1);
          insf_nxt  = 1'b0;
          rdv_nxt   = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (cnt_r == '0) begin
          if (free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{entry_valid: 1'b0, entry_key: '0, min_value: '0,
                              overflowed: ovf_r, last: 1'b1};
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          if (loadnow) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{entry_valid: 1'b1,
                              entry_key: FIELD_W'($signed(q_key)),
                              min_value: FIELD_W'($signed(q_min)),
                              overflowed: ovf_r, last: orem_r == CW'(1)};
            orem_nxt      = orem_r - CW'(1);
            rdv_nxt       = 1'b0;
            if (orem_r == CW'(1)) begin
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end
          end
          if (rem_r != '0 && (!rdv_r || loadnow)) begin
            ram_re    = 1'b1;
            ram_raddr = src_r[AW-1:0];
            src_nxt   = up_r ? src_r + CW'(1) : src_r - CW'(1);
            rem_nxt   = rem_r - CW'(1);
            rdv_nxt   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (nf) begin
      rdv_nxt = 1'b0;
      if (cnt_r < CW'(CAPACITY)) begin
        up_nxt    = 1'b1;
        src_nxt   = cnt_r - CW'(1);
        rem_nxt   = cnt_r - p_r;
        ins_nxt   = p_r[AW-1:0];
        insf_nxt  = 1'b1;
        evc_nxt   = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_SHIFT;
      end else if (lim_act && lim_fits) begin
        if (p_r != '0) begin
          up_nxt    = 1'b0;
          src_nxt   = CW'(1);
          rem_nxt   = p_r - CW'(1);
          ins_nxt   = AW'(p_r - CW'(1));
          insf_nxt  = 1'b1;
          evc_nxt   = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end else begin
        ovf_nxt   = 1'b1;
        state_nxt = S_EVCHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      lim_r       <= '1;
      desc_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rdv_r       <= rdv_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LIMIT:  lim_r  <= cfg_wdata;
          CFG_DESCENDING: desc_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    orem_r     <= orem_nxt;
    last_r     <= last_nxt;
    ins_r      <= ins_nxt;
    up_r       <= up_nxt;
    insf_r     <= insf_nxt;
    evc_r      <= evc_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  `KMT_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt_r) <= 32'(CAPACITY), "entry count above capacity")
  `KMT_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !ram_we, "table written while idle")
  `KMT_ASSERT_NXT(a_emit_start, in_valid && in_ready && in_data.op, state_r == S_EMIT,
                  "emit word did not start an emit")

endmodule

>>> test/keyed_min_table_topn_tb.sv
// Testbench of keyed_min_table_topn: a sorted key table keeping a minimum per key.
// Depends on kmt_pkg and the block; predicts every emitted word and compares field by field.
`timescale 1ns / 100ps

module keyed_min_table_topn_tb;
  import kmt_pkg::*;

  localparam int CAP = KMT_CAPACITY;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_KEY_LIMIT;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  logic signed [63:0] tbl_keys [CAP];
  logic signed [63:0] tbl_mins [CAP];
  int tbl_count;
  bit tbl_overflow;
  logic signed [LIMIT_W-1:0] limit_reg;
  bit descending;

  out_word_t emit_queue [$];
  int mismatches;
  int idle_cycles;
  bit timed_out;
  bit quiet_mode;
  bit stall_out;
  int stall_left;

  keyed_min_table_topn dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic drop_smallest();
    for (int i = 1; i < tbl_count; i++) begin
      tbl_keys[i-1] = tbl_keys[i];
      tbl_mins[i-1] = tbl_mins[i];
    end
    if (tbl_count > 0) tbl_count--;
  endtask

  task automatic predict_word(in_word_t w);
    int lim;
    int p;
    bit evicted;
    logic signed [63:0] key;
    logic signed [63:0] val;
    out_word_t r;
    lim = (limit_reg < 0) ? -1 : int'(limit_reg);
    evicted = 1'b0;
    if (w.op) begin
      if (tbl_count == 0) begin
        r = '0;
        r.overflowed = tbl_overflow;
        r.last = 1'b1;
        emit_queue.push_back(r);
      end else begin
        for (int k = 0; k < tbl_count; k++) begin
          p = descending ? tbl_count - 1 - k : k;
          r.entry_valid = 1'b1;
          r.entry_key = tbl_keys[p];
          r.min_value = tbl_mins[p];
          r.overflowed = tbl_overflow;
          r.last = (k + 1 == tbl_count);
          emit_queue.push_back(r);
        end
      end
      tbl_count = 0;
      tbl_overflow = 1'b0;
      return;
    end
    if (!w.condition || w.condition_null) return;
    if (!w.value_null && !w.category_null) begin
      key = w.category;
      val = w.value;
      p = 0;
      while (p < tbl_count && tbl_keys[p] < key) p++;
      if (p < tbl_count && tbl_keys[p] == key) begin
        if (val < tbl_mins[p]) tbl_mins[p] = val;
      end else if (tbl_count < CAP) begin
        for (int i = tbl_count; i > p; i--) begin
          tbl_keys[i] = tbl_keys[i-1];
          tbl_mins[i] = tbl_mins[i-1];
        end
        tbl_keys[p] = key;
        tbl_mins[p] = val;
        tbl_count++;
      end else if (lim >= 0 && lim <= CAP) begin
        evicted = 1'b1;
        if (p > 0) begin
          for (int i = 1; i < p; i++) begin
            tbl_keys[i-1] = tbl_keys[i];
            tbl_mins[i-1] = tbl_mins[i];
          end
          tbl_keys[p-1] = key;
          tbl_mins[p-1] = val;
        end
      end else begin
        tbl_overflow = 1'b1;
      end
    end
    if (!evicted && lim >= 0 && tbl_count > lim) drop_smallest();
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (emit_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (CAP * 3 + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LIMIT_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_LIMIT) limit_reg = data;
    else descending = data[0];
  endtask

  function automatic in_word_t make_update(logic signed [63:0] key, logic signed [63:0] val);
    in_word_t w;
    w = '0;
    w.condition = 1'b1;
    w.category = key;
    w.value = val;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return in_word_t'(raw[$bits(in_word_t)-1:0]);
  endfunction

  function automatic in_word_t make_emit();
    in_word_t w;
    w = rand_word();
    w.op = 1'b1;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_extremes();
    in_word_t w;
    send_word(make_emit());
    send_word(make_update(64'sh8000_0000_0000_0000, 64'sh7fff_ffff_ffff_ffff));
    send_word(make_update(64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000));
    send_word(make_update(64'sh7fff_ffff_ffff_ffff, -64'sd1));
    send_word(make_update(64'sd0, 64'sd0));
    send_word(make_update(64'sd0, 64'sd5));
    w = make_update(64'sd9, 64'sd1); w.value_null = 1'b1; send_word(w);
    w = make_update(64'sd10, 64'sd1); w.category_null = 1'b1; send_word(w);
    w = make_update(64'sd11, 64'sd1); w.condition = 1'b0; send_word(w);
    w = make_update(64'sd12, 64'sd1); w.condition_null = 1'b1; send_word(w);
    send_word(make_emit());
    send_word(make_emit());
  endtask

  task automatic test_overflow_no_limit();
    for (int i = 0; i < CAP + 2; i++) send_word(make_update(64'(i * 3), rand64()));
    send_word(make_emit());
  endtask

  task automatic test_limit_eviction();
    write_reg(CFG_KEY_LIMIT, 6'd4);
    write_reg(CFG_DESCENDING, 6'd1);
    for (int i = 0; i < 8; i++) send_word(make_update(64'(100 - i * 7), 64'(i)));
    send_word(make_emit());
    write_reg(CFG_KEY_LIMIT, 6'd0);
    send_word(make_update(64'sd1, 64'sd1));
    send_word(make_emit());
    write_reg(CFG_KEY_LIMIT, 6'd16);
    for (int i = 0; i < CAP + 3; i++) send_word(make_update(64'(i - 5), rand64()));
    send_word(make_update(-64'sd100, 64'sd0));
    write_reg(CFG_KEY_LIMIT, 6'd3);
    send_word(make_update(64'sd2, 64'sd0));
    send_word(make_update(64'sd3, 64'sd0));
    send_word(make_emit());
  endtask

  task automatic test_random(int count);
    in_word_t w;
    logic signed [63:0] keypool;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        write_reg(CFG_KEY_LIMIT, 6'($urandom_range(0, 17)) | ($urandom_range(0, 3) == 0 ? 6'h3f : 6'h0));
        write_reg(CFG_DESCENDING, 6'($urandom_range(0, 1)));
      end
      if (n == count - 40) quiet_mode = 1'b1;
      if (n == 60) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        send_word(make_emit());
      end else begin
        keypool = $urandom_range(0, 4) == 0 ? rand64() : 64'($signed($urandom_range(0, 40)) - 20);
        w = make_update(keypool, $urandom_range(0, 2) == 0 ? rand64() : 64'($urandom_range(0, 99)));
        if ($urandom_range(0, 9) == 0) w = rand_word();
        w.op = 1'b0;
        send_word(w);
      end
    end
    send_word(make_emit());
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet_mode) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (emit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        exp_w = emit_queue.pop_front();
        if (out_data.entry_valid !== exp_w.entry_valid || out_data.entry_key !== exp_w.entry_key
            || out_data.min_value !== exp_w.min_value || out_data.overflowed !== exp_w.overflowed
            || out_data.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_w, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  initial begin
    wait (timed_out);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tbl_count = 0;
    tbl_overflow = 1'b0;
    limit_reg = -6'sd1;
    descending = 1'b0;
    mismatches = 0;
    quiet_mode = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_overflow_no_limit();
    test_limit_eviction();
    write_reg(CFG_KEY_LIMIT, 6'h3f);
    write_reg(CFG_DESCENDING, 6'd0);
    test_random(180);
    wait_drained();
    if (mismatches == 0 && emit_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
